// ===== rtl/core/sps_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the prime sieve.
package sps_pkg;

    localparam int unsigned SEG_MAX_BYTES = 1024;
    localparam int unsigned STORE_DEPTH   = 4096;
    localparam int unsigned VALUE_BITS    = 40;

    localparam int unsigned PRIME_W    = 40;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_USER_W = 2;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SEG_BYTES_W = 11;
    localparam int unsigned SEG_LIMIT_W = 32;

    localparam logic [SEG_BYTES_W-1:0] SEG_BYTES_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LIMIT = 8'd1;

    typedef enum logic [1:0] {
        KIND_RESTART,
        KIND_EXHAUSTED,
        KIND_PRIME
    } kind_t;

    typedef struct packed {
        logic  clr_all;
        logic  calc_base;
        logic  clr_start;
        logic  clr_step;
        logic  k_zero;
        logic  store_rd;
        logic  div_start;
        logic  mark_init;
        logic  mark_step;
        logic  k_inc;
        logic  seg_ready;
        logic  seg_next;
        logic  scan_rd;
        logic  scan_test;
        logic  out_load;
        kind_t kind;
    } sps_cmd_t;

    typedef struct packed {
        logic seg_ready;
        logic no_more;
        logic clr_last;
        logic k_done;
        logic p_small;
        logic div_done;
        logic mark_done;
        logic scan_end;
        logic found;
        logic out_free;
    } sps_stat_t;

endpackage

// ===== rtl/core/sps_div.sv =====
// Restoring remainder unit: one quotient bit per cycle.
module sps_div #(
    parameter int unsigned VALUE_BITS = sps_pkg::VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] num,
    input  logic [VALUE_BITS-1:0] den,
    output logic                  busy,
    output logic [VALUE_BITS-1:0] rem
);

    localparam int unsigned CW = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [VALUE_BITS-1:0] den_reg, den_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS:0]   trial;

    assign trial = {rem_reg, num_reg[VALUE_BITS-1]};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_BITS);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = VALUE_BITS'(trial - {1'b0, den_reg});
            end else begin
                rem_next = VALUE_BITS'(trial);
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/sps_dp.sv =====
// Sieve datapath: registers, segment bitmap, prime store, remainder unit and result register.
module sps_dp #(
    parameter int unsigned SEG_MAX_BYTES = sps_pkg::SEG_MAX_BYTES,
    parameter int unsigned STORE_DEPTH   = sps_pkg::STORE_DEPTH,
    parameter int unsigned VALUE_BITS    = sps_pkg::VALUE_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sps_pkg::sps_cmd_t                cmd,
    output sps_pkg::sps_stat_t               stat,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sps_pkg::PRIME_W-1:0]      m_tdata,
    output logic [sps_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int unsigned BM_DEPTH = SEG_MAX_BYTES * 8;
    localparam int unsigned SBW      = $clog2(BM_DEPTH);
    localparam int unsigned BITS_W   = SBW + 1;
    localparam int unsigned PAW      = $clog2(STORE_DEPTH);
    localparam int unsigned PCW      = $clog2(STORE_DEPTH + 1);
    localparam int unsigned BW       = sps_pkg::SEG_LIMIT_W + BITS_W;
    localparam int unsigned IW       = ((VALUE_BITS > BITS_W) ? VALUE_BITS : BITS_W) + 1;
    localparam int unsigned FW       = ((BW > VALUE_BITS) ? BW : VALUE_BITS) + 1;

    // configuration
    logic [sps_pkg::SEG_BYTES_W-1:0] seg_bytes_reg;
    logic [sps_pkg::SEG_LIMIT_W-1:0] seg_limit_reg;

    // sieve state
    logic [PCW-1:0]                  count_reg;
    logic [sps_pkg::SEG_LIMIT_W-1:0] idx_reg;
    logic [BITS_W-1:0]               scan_reg;
    logic                            ready_reg;
    logic                            ovf_reg;
    logic [BW-1:0]                   base_reg;
    logic [SBW-1:0]                  clr_reg;
    logic [PCW-1:0]                  k_reg;
    logic [VALUE_BITS-1:0]           p_reg;
    logic [VALUE_BITS-1:0]           n_reg;
    logic [VALUE_BITS-1:0]           step_reg;
    logic [IW-1:0]                   i_reg;

    // result register
    logic                            out_valid_reg;
    logic [VALUE_BITS-1:0]           out_val_reg;
    logic                            out_exh_reg;
    logic                            out_full_reg;

    // memories
    logic                            bm_mem [BM_DEPTH];
    logic                            bm_q;
    logic [VALUE_BITS-1:0]           st_mem [STORE_DEPTH];
    logic [VALUE_BITS-1:0]           st_q;

    logic [31:0]                     bytes32;
    logic [31:0]                     bytes_eff;
    logic [BITS_W-1:0]               bits_w;
    logic [VALUE_BITS-1:0]           n_cur;
    logic [FW-1:0]                   seg_top;
    logic                            div_busy;
    logic [VALUE_BITS-1:0]           div_rem;
    logic [VALUE_BITS-1:0]           first;
    logic                            bm_we;
    logic [SBW-1:0]                  bm_wa;
    logic [63:0]                     val64;

    // effective segment size, zero taken as one, saturated at the bitmap size
    always_comb begin
        bytes32 = 32'(seg_bytes_reg);
        if (bytes32 == 32'd0) begin
            bytes_eff = 32'd1;
        end else if (bytes32 > 32'(SEG_MAX_BYTES)) begin
            bytes_eff = 32'(SEG_MAX_BYTES);
        end else begin
            bytes_eff = bytes32;
        end
        bits_w = BITS_W'(bytes_eff * 32'd8);
    end

    assign n_cur   = VALUE_BITS'(base_reg) + VALUE_BITS'(scan_reg);
    assign seg_top = FW'(base_reg) + FW'(bits_w) - FW'(1);
    assign first   = (div_rem != '0) ? (p_reg - div_rem) : '0;

    always_comb begin
        stat           = '0;
        stat.seg_ready = ready_reg;
        stat.no_more   = ((seg_limit_reg != '0) && (idx_reg >= seg_limit_reg))
                       || (idx_reg == '1)
                       || (seg_top > FW'({VALUE_BITS{1'b1}}));
        stat.clr_last  = (clr_reg == SBW'(BM_DEPTH - 1));
        stat.k_done    = (k_reg == count_reg);
        stat.p_small   = (p_reg < VALUE_BITS'(2));
        stat.div_done  = !div_busy;
        stat.mark_done = (i_reg >= IW'(bits_w));
        stat.scan_end  = (scan_reg >= bits_w);
        stat.found     = !bm_q && (n_cur > VALUE_BITS'(1));
        stat.out_free  = !out_valid_reg || m_tready;
    end

    sps_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (VALUE_BITS'(base_reg)),
        .den     (st_q),
        .busy    (div_busy),
        .rem     (div_rem)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_bytes_reg <= sps_pkg::SEG_BYTES_RST;
            seg_limit_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sps_pkg::CFG_SEG_BYTES: seg_bytes_reg <= cfg_data[sps_pkg::SEG_BYTES_W-1:0];
                sps_pkg::CFG_SEG_LIMIT: seg_limit_reg <= cfg_data[sps_pkg::SEG_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            scan_reg      <= '0;
            ready_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_all) begin
                count_reg <= '0;
                idx_reg   <= '0;
                scan_reg  <= '0;
                ready_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.seg_ready) begin
                scan_reg  <= '0;
                ready_reg <= 1'b1;
            end
            if (cmd.seg_next) begin
                ready_reg <= 1'b0;
                idx_reg   <= idx_reg + sps_pkg::SEG_LIMIT_W'(1);
            end
            if (cmd.scan_test) begin
                scan_reg <= scan_reg + BITS_W'(1);
                if (stat.found) begin
                    if (count_reg < PCW'(STORE_DEPTH)) begin
                        count_reg <= count_reg + PCW'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.calc_base) begin
            base_reg <= BW'(idx_reg) * BW'(bits_w);
        end
        if (cmd.clr_start) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + SBW'(1);
        end
        if (cmd.k_zero) begin
            k_reg <= '0;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + PCW'(1);
        end
        if (cmd.div_start) begin
            p_reg <= st_q;
        end
        if (cmd.mark_init) begin
            i_reg    <= IW'(first);
            step_reg <= p_reg;
        end else if (cmd.scan_test && stat.found) begin
            i_reg    <= IW'(scan_reg);
            step_reg <= n_cur;
            n_reg    <= n_cur;
        end else if (cmd.mark_step) begin
            i_reg <= i_reg + IW'(step_reg);
        end
        if (cmd.out_load) begin
            case (cmd.kind)
                sps_pkg::KIND_PRIME: begin
                    out_val_reg <= n_reg;
                    out_exh_reg <= 1'b0;
                end
                sps_pkg::KIND_EXHAUSTED: begin
                    out_val_reg <= '0;
                    out_exh_reg <= 1'b1;
                end
                default: begin
                    out_val_reg <= '0;
                    out_exh_reg <= 1'b0;
                end
            endcase
            out_full_reg <= ovf_reg;
        end
    end

    // segment bitmap, one bit per number
    assign bm_we = cmd.clr_step || cmd.mark_step;
    assign bm_wa = cmd.clr_step ? clr_reg : i_reg[SBW-1:0];

    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_wa] <= cmd.mark_step;
        end
        if (cmd.scan_rd) begin
            bm_q <= bm_mem[scan_reg[SBW-1:0]];
        end
    end

    // prime store
    always_ff @(posedge aclk) begin
        if (cmd.scan_test && stat.found && (count_reg < PCW'(STORE_DEPTH))) begin
            st_mem[count_reg[PAW-1:0]] <= n_cur;
        end
        if (cmd.store_rd) begin
            st_q <= st_mem[k_reg[PAW-1:0]];
        end
    end

    assign val64    = 64'(out_val_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = val64[sps_pkg::PRIME_W-1:0];
    assign m_tuser  = {out_full_reg, out_exh_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PCW'(STORE_DEPTH))
        else $error("prime count beyond store depth");

    a_mark_in_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mark_step |-> (i_reg < IW'(bits_w)))
        else $error("mark beyond segment end");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovf_reg && !cmd.clr_all) |=> ovf_reg)
        else $error("store full flag dropped without restart");
`endif

endmodule

// ===== rtl/core/sps_ctrl.sv =====
// Sieve sequencer: request handling, segment preparation, scanning and result hand-off.
module sps_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               restart,
    output sps_pkg::sps_cmd_t  cmd,
    input  sps_pkg::sps_stat_t stat
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_BASE  = 12'b0000_0000_0010,
        ST_CHECK = 12'b0000_0000_0100,
        ST_CLEAR = 12'b0000_0000_1000,
        ST_PRD   = 12'b0000_0001_0000,
        ST_PCAP  = 12'b0000_0010_0000,
        ST_DIV   = 12'b0000_0100_0000,
        ST_MARKS = 12'b0000_1000_0000,
        ST_SCRD  = 12'b0001_0000_0000,
        ST_SCT   = 12'b0010_0000_0000,
        ST_MARKP = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    sps_pkg::kind_t        kind_reg, kind_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (restart) begin
                        cmd.clr_all = 1'b1;
                        kind_next   = sps_pkg::KIND_RESTART;
                        state_next  = ST_EMIT;
                    end else begin
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                cmd.calc_base = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.seg_ready) begin
                    state_next = ST_SCRD;
                end else if (stat.no_more) begin
                    kind_next  = sps_pkg::KIND_EXHAUSTED;
                    state_next = ST_EMIT;
                end else begin
                    cmd.clr_start = 1'b1;
                    state_next    = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    cmd.k_zero = 1'b1;
                    state_next = ST_PRD;
                end
            end
            ST_PRD: begin
                if (stat.k_done) begin
                    cmd.seg_ready = 1'b1;
                    state_next    = ST_SCRD;
                end else begin
                    cmd.store_rd = 1'b1;
                    state_next   = ST_PCAP;
                end
            end
            ST_PCAP: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    if (stat.p_small) begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_PRD;
                    end else begin
                        cmd.mark_init = 1'b1;
                        state_next    = ST_MARKS;
                    end
                end
            end
            ST_MARKS: begin
                if (stat.mark_done) begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_PRD;
                end else begin
                    cmd.mark_step = 1'b1;
                end
            end
            ST_SCRD: begin
                if (stat.scan_end) begin
                    cmd.seg_next = 1'b1;
                    state_next   = ST_BASE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCT;
                end
            end
            ST_SCT: begin
                cmd.scan_test = 1'b1;
                if (stat.found) begin
                    kind_next  = sps_pkg::KIND_PRIME;
                    state_next = ST_MARKP;
                end else begin
                    state_next = ST_SCRD;
                end
            end
            ST_MARKP: begin
                if (stat.mark_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.mark_step = 1'b1;
                end
            end
            ST_EMIT: begin
                // hold until the result register can take the beat
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= sps_pkg::KIND_RESTART;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ===== rtl/core/segmented_prime_sieve_top.sv =====
// Segmented sieve prime generator: top level joining sequencer and datapath.
// Each input beat (s_tdata[0] = restart) yields one result beat: the next prime in ascending
// order, zero with the exhausted flag once the segment limit or the value range is reached, or
// zero after a restart. A request inside a prepared segment reads and tests each number in
// turn and then marks the multiples of the prime p found in the bitmap. Entering a new segment
// first clears the whole bitmap, one bit a cycle, then for each stored prime takes the
// remainder of the segment base with the bit-serial remainder unit and marks its multiples
// in the single-port bitmap. A result waits in an output register, so the next request is
// taken while it is still held.
module segmented_prime_sieve_top #(
    parameter int unsigned SEGMENT_MAX_BYTES = sps_pkg::SEG_MAX_BYTES,
    parameter int unsigned PRIME_STORE_DEPTH = sps_pkg::STORE_DEPTH,
    parameter int unsigned VALUE_BITS        = sps_pkg::VALUE_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sps_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sps_pkg::PRIME_W-1:0]    m_tdata,   // [39:0] prime_value
    output logic [sps_pkg::OUT_USER_W-1:0] m_tuser,   // [0] exhausted, [1] store_full
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data
);

    sps_pkg::sps_cmd_t  cmd;
    sps_pkg::sps_stat_t stat;

    sps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .cmd      (cmd),
        .stat     (stat)
    );

    sps_dp #(
        .SEG_MAX_BYTES (SEGMENT_MAX_BYTES),
        .STORE_DEPTH   (PRIME_STORE_DEPTH),
        .VALUE_BITS    (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
